FILE: sv/clre_pkg.sv
// ----------------------------------------------------------------------------
// clre_pkg
// Shared types, constants and run flush logic of the code length run length
// encoder.
// ----------------------------------------------------------------------------
package clre_pkg;

   localparam int CodeLenW    = 4;
   localparam int SymW        = 5;
   localparam int XvalW       = 7;
   localparam int XbitsW      = 3;
   localparam int TableCodeW  = 7;
   localparam int TableLenW   = 3;
   localparam int TableW      = TableCodeW + TableLenW;
   localparam int TableDepth  = 19;
   localparam int TableAddrW  = 5;
   localparam int MaxResults  = 6;
   localparam int CountW      = 8;

   localparam logic FuncLoad = 1'b0;
   localparam logic FuncLen  = 1'b1;

   localparam logic [SymW-1:0]   SymRep       = 5'd16;
   localparam logic [SymW-1:0]   SymZeroShort = 5'd17;
   localparam logic [SymW-1:0]   SymZeroLong  = 5'd18;
   localparam logic [SymW-1:0]   PriorNone    = 5'd16;
   localparam logic [CountW-1:0] ZeroRunMax   = 8'd138;
   localparam logic [CountW-1:0] RepRunMax    = 8'd6;
   localparam logic [CountW-1:0] PlainRunMax  = 8'd7;
   localparam logic [2:0]        ShortRunMin  = 3'd3;
   localparam logic [2:0]        PlainRunMin  = 3'd4;
   localparam logic [CountW-1:0] ShortZeroMax = 8'd10;

   typedef struct packed {
      logic [SymW-1:0]   sym;
      logic [XvalW-1:0]  xval;
      logic [XbitsW-1:0] xbits;
      logic              last_result;
      logic              tree_done;
   } plan_ent_type;

   typedef struct packed {
      logic [1:0]             n;
      plan_ent_type [2:0]     ent;
   } flush_type;

   typedef struct packed {
      logic [2:0]                    n;
      plan_ent_type [MaxResults-1:0] ent;
   } plan_type;

   typedef struct packed {
      logic                  we;
      logic [TableAddrW-1:0] addr;
      logic [TableW-1:0]     data;
   } table_wr_type;

   function automatic plan_ent_type make_ent(logic [SymW-1:0] sym, logic [XvalW-1:0] xval,
                                             logic [XbitsW-1:0] xbits);
      plan_ent_type e;
      e.sym         = sym;
      e.xval        = xval;
      e.xbits       = xbits;
      e.last_result = 1'b0;
      e.tree_done   = 1'b0;
      return e;
   endfunction

   function automatic flush_type flush_run(logic [CodeLenW-1:0] value, logic [CountW-1:0] count,
                                           logic [SymW-1:0] prior, logic [2:0] min_len);
      flush_type       f;
      logic [CountW-1:0] rep;
      f = '0;
      rep = '0;
      if (count < {5'd0, min_len}) begin
         f.n = count[1:0];
         for (int i = 0; i < 3; i++) begin
            f.ent[i] = make_ent({1'b0, value}, '0, '0);
         end
      end else if (value != '0) begin
         if ({1'b0, value} != prior) begin
            rep = count - 8'd4;
            f.ent[0] = make_ent({1'b0, value}, '0, '0);
            f.ent[1] = make_ent(SymRep, rep[XvalW-1:0], 3'd2);
            f.n = 2'd2;
         end else begin
            rep = count - 8'd3;
            f.ent[0] = make_ent(SymRep, rep[XvalW-1:0], 3'd2);
            f.n = 2'd1;
         end
      end else if (count <= ShortZeroMax) begin
         rep = count - 8'd3;
         f.ent[0] = make_ent(SymZeroShort, rep[XvalW-1:0], 3'd3);
         f.n = 2'd1;
      end else begin
         rep = count - 8'd11;
         f.ent[0] = make_ent(SymZeroLong, rep[XvalW-1:0], 3'd7);
         f.n = 2'd1;
      end
      return f;
   endfunction

endpackage

FILE: sv/clre_if.sv
// ----------------------------------------------------------------------------
// clre_if
// Request and response channels of the code length run length encoder.
// ----------------------------------------------------------------------------
interface clre_req_if
   import clre_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [CodeLenW-1:0]   code_len;
   logic                  last;
   logic [TableAddrW-1:0] table_index;
   logic [TableCodeW-1:0] table_code;
   logic [TableLenW-1:0]  table_len;

   modport source (output valid, func, code_len, last, table_index, table_code, table_len,
                   input ready);
   modport sink (input valid, func, code_len, last, table_index, table_code, table_len,
                 output ready);
endinterface

interface clre_rsp_if
   import clre_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [SymW-1:0]       symbol;
   logic [TableCodeW-1:0] code_value;
   logic [TableLenW-1:0]  code_bits;
   logic [XvalW-1:0]      extra_value;
   logic [XbitsW-1:0]     extra_bits;
   logic                  last_result;
   logic                  tree_done;

   modport source (output valid, symbol, code_value, code_bits, extra_value, extra_bits,
                   last_result, tree_done, input ready);
   modport sink (input valid, symbol, code_value, code_bits, extra_value, extra_bits,
                 last_result, tree_done, output ready);
endinterface

FILE: sv/clre_ram.sv
// ----------------------------------------------------------------------------
// clre_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clre_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/clre_run.sv
// ----------------------------------------------------------------------------
// clre_run
// Run tracker: holds the open run and plans the symbols that one code
// length closes, including the flush on the final length of a tree.
// ----------------------------------------------------------------------------
module clre_run
   import clre_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [CodeLenW-1:0] code_len,
   input  logic                last,
   output plan_type            plan
);

   logic [CodeLenW-1:0] run_value_ff, run_value_in;
   logic [CountW-1:0]   run_count_ff, run_count_in;
   logic [SymW-1:0]     prior_ff, prior_in;
   logic [CountW-1:0]   run_max_ff, run_max_in;
   logic [2:0]          run_min_ff, run_min_in;
   logic                run_open_ff, run_open_in;

   always_comb begin
      flush_type           fa;
      flush_type           fb;
      logic [2:0]          na;
      logic [2:0]          nb;
      logic [2:0]          j;
      logic [CodeLenW-1:0] value_mid;
      logic [CountW-1:0]   count_mid;
      logic [SymW-1:0]     prior_mid;
      logic [CountW-1:0]   max_mid;
      logic [2:0]          min_mid;

      value_mid = run_value_ff;
      count_mid = run_count_ff;
      prior_mid = prior_ff;
      max_mid   = run_max_ff;
      min_mid   = run_min_ff;
      na        = '0;
      nb        = '0;
      j         = '0;
      fa        = flush_run(run_value_ff, run_count_ff, prior_ff, run_min_ff);

      if (!run_open_ff) begin
         if (code_len == '0) begin
            max_mid = ZeroRunMax;
            min_mid = ShortRunMin;
         end
         value_mid = code_len;
         count_mid = 8'd1;
      end else if (run_count_ff < run_max_ff && run_value_ff == code_len) begin
         count_mid = run_count_ff + 8'd1;
      end else begin
         na        = {1'b0, fa.n};
         prior_mid = {1'b0, run_value_ff};
         if (code_len == '0) begin
            max_mid = ZeroRunMax;
            min_mid = ShortRunMin;
         end else if (run_value_ff == code_len) begin
            max_mid = RepRunMax;
            min_mid = ShortRunMin;
         end else begin
            max_mid = PlainRunMax;
            min_mid = PlainRunMin;
         end
         value_mid = code_len;
         count_mid = 8'd1;
      end

      fb = flush_run(value_mid, count_mid, prior_mid, min_mid);
      if (last) begin
         nb = {1'b0, fb.n};
      end

      plan.n = na + nb;
      for (int i = 0; i < MaxResults; i++) begin
         j = 3'(i) - na;
         if (3'(i) < na) begin
            plan.ent[i] = fa.ent[2'(i)];
         end else begin
            plan.ent[i] = fb.ent[j[1:0]];
         end
         plan.ent[i].last_result = (3'(i) == plan.n - 3'd1);
         plan.ent[i].tree_done   = (3'(i) == plan.n - 3'd1) && last;
      end

      if (last) begin
         run_value_in = '0;
         run_count_in = '0;
         prior_in     = PriorNone;
         run_max_in   = PlainRunMax;
         run_min_in   = PlainRunMin;
         run_open_in  = 1'b0;
      end else begin
         run_value_in = value_mid;
         run_count_in = count_mid;
         prior_in     = prior_mid;
         run_max_in   = max_mid;
         run_min_in   = min_mid;
         run_open_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= '0;
         run_count_ff <= '0;
         prior_ff     <= PriorNone;
         run_max_ff   <= PlainRunMax;
         run_min_ff   <= PlainRunMin;
         run_open_ff  <= 1'b0;
      end else if (take) begin
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
         prior_ff     <= prior_in;
         run_max_ff   <= run_max_in;
         run_min_ff   <= run_min_in;
         run_open_ff  <= run_open_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (run_count_ff != '0 && run_count_ff <= run_max_ff))
      else $error("open run count out of range");

   assert property (@(posedge clock) disable iff (reset)
      take |-> (plan.n <= 3'(MaxResults)))
      else $error("plan exceeds result limit");

   assert property (@(posedge clock) disable iff (reset)
      (take && last) |=> !run_open_ff)
      else $error("run still open after final length");

endmodule

FILE: sv/clre_emit.sv
// ----------------------------------------------------------------------------
// clre_emit
// Symbol emitter: holds the planned symbols of one item, looks each one up
// in the code table RAM and presents it through a registered output stage.
// ----------------------------------------------------------------------------
module clre_emit
   import clre_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  plan_type     plan,
   input  table_wr_type table_wr,
   output logic         item_ready,
   clre_rsp_if.source   rsp
);

   plan_ent_type [MaxResults-1:0] plan_ff;
   logic [2:0]                    cnt_ff;
   logic [2:0]                    idx_ff;
   plan_ent_type                  meta_ff;
   logic                          meta_vld_ff, meta_vld_in;
   plan_ent_type                  out_ff;
   logic [TableW-1:0]             out_code_ff;
   logic                          out_vld_ff, out_vld_in;
   logic [TableW-1:0]             rdata;
   plan_ent_type                  cur_ent;
   logic                          busy;
   logic                          out_adv;
   logic                          issue;
   logic                          final_issue;

   assign cur_ent     = plan_ff[idx_ff];
   assign busy        = idx_ff < cnt_ff;
   assign out_adv     = !out_vld_ff || rsp.ready;
   assign issue       = busy && (!meta_vld_ff || out_adv);
   assign final_issue = issue && (idx_ff == cnt_ff - 3'd1);
   assign item_ready  = !busy || final_issue;

   clre_ram #(
      .WIDTH (TableW),
      .DEPTH (TableDepth)
   ) u_table (
      .clock (clock),
      .we    (table_wr.we),
      .waddr (table_wr.addr),
      .wdata (table_wr.data),
      .re    (issue),
      .raddr (cur_ent.sym),
      .rdata (rdata)
   );

   always_comb begin
      if (issue) begin
         meta_vld_in = 1'b1;
      end else if (out_adv) begin
         meta_vld_in = 1'b0;
      end else begin
         meta_vld_in = meta_vld_ff;
      end
      if (out_adv) begin
         out_vld_in = meta_vld_ff;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         idx_ff      <= '0;
         meta_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (load) begin
            cnt_ff <= plan.n;
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + 3'd1;
         end
         meta_vld_ff <= meta_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff <= plan.ent;
      end
      if (issue) begin
         meta_ff <= cur_ent;
      end
      if (out_adv && meta_vld_ff) begin
         out_ff      <= meta_ff;
         out_code_ff <= rdata;
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.symbol      = out_ff.sym;
   assign rsp.code_value  = out_code_ff[TableCodeW-1:0];
   assign rsp.code_bits   = out_code_ff[TableW-1:TableCodeW];
   assign rsp.extra_value = out_ff.xval;
   assign rsp.extra_bits  = out_ff.xbits;
   assign rsp.last_result = out_ff.last_result;
   assign rsp.tree_done   = out_ff.tree_done;

   assert property (@(posedge clock) disable iff (reset)
      (idx_ff <= cnt_ff) && (cnt_ff <= 3'(MaxResults)))
      else $error("emit index beyond planned symbols");

   assert property (@(posedge clock) disable iff (reset)
      (meta_vld_ff && !out_adv) |-> !issue)
      else $error("table read issued over a held lookup");

   assert property (@(posedge clock) disable iff (reset)
      load |-> item_ready)
      else $error("new plan loaded while symbols remain");

   assert property (@(posedge clock) disable iff (reset)
      (meta_vld_ff && !out_adv) |=> (meta_vld_ff && $stable(meta_ff)))
      else $error("lookup stage lost while output stalled");

endmodule

FILE: sv/code_length_run_length_encoder.sv
// ----------------------------------------------------------------------------
// code_length_run_length_encoder
// Deflate code length run length encoder: groups code lengths into runs and
// emits code length symbols 0..18 with their Huffman codes and extra bits.
// ----------------------------------------------------------------------------
// The plan of a taken item is registered, then each symbol passes the lookup and output registers.
// Throughput: one item per cycle while each item yields at most one symbol and the output does
//   not stall; an item yielding n symbols (n <= 4) makes one table read per symbol.
// Reset clears the run state and all pipeline valid flags; the code table
//   holds no defined value until loaded.
// ----------------------------------------------------------------------------
module code_length_run_length_encoder
   import clre_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   clre_req_if.sink   req_chan,
   clre_rsp_if.source rsp_chan
);

   logic         accept;
   logic         item_ready;
   plan_type     plan;
   table_wr_type table_wr;

   assign req_chan.ready = item_ready;
   assign accept         = req_chan.valid && item_ready;

   assign table_wr.we   = accept && (req_chan.func == FuncLoad) &&
                          (req_chan.table_index < 5'(TableDepth));
   assign table_wr.addr = req_chan.table_index;
   assign table_wr.data = {req_chan.table_len, req_chan.table_code};

   clre_run u_run (
      .clock    (clock),
      .reset    (reset),
      .take     (accept && (req_chan.func == FuncLen)),
      .code_len (req_chan.code_len),
      .last     (req_chan.last),
      .plan     (plan)
   );

   clre_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && (req_chan.func == FuncLen)),
      .plan       (plan),
      .table_wr   (table_wr),
      .item_ready (item_ready),
      .rsp        (rsp_chan)
   );

endmodule

FILE: dv/code_length_run_length_encoder_tb.sv
// ----------------------------------------------------------------------------
// code_length_run_length_encoder_tb
// Drives code table loads and code length trees into the encoder, predicts
// the Deflate code length symbols of each accepted item, and compares every
// returned symbol field by field. Both sides idle at random. One phase holds
// the response side off long enough to back up the input.
// ----------------------------------------------------------------------------
module code_length_run_length_encoder_tb
   import clre_pkg::*;
();

   localparam int LongHold     = 200;
   localparam int SettleCycles = 8;
   localparam int RandomItems  = 25;
   localparam int DrainLimit   = 50000;
   localparam int TimeLimit    = 4000000;

   localparam logic [XbitsW-1:0] RepXbits       = 3'd2;
   localparam logic [XbitsW-1:0] ZeroShortXbits = 3'd3;
   localparam logic [XbitsW-1:0] ZeroLongXbits  = 3'd7;
   localparam logic [CountW-1:0] RepBase        = 8'd3;
   localparam logic [CountW-1:0] ZeroLongBase   = 8'd11;

   typedef struct packed {
      logic                  func;
      logic [CodeLenW-1:0]   code_len;
      logic                  last;
      logic [TableAddrW-1:0] table_index;
      logic [TableCodeW-1:0] table_code;
      logic [TableLenW-1:0]  table_len;
   } tree_item_type;

   typedef struct packed {
      logic [SymW-1:0]       symbol;
      logic [TableCodeW-1:0] code_value;
      logic [TableLenW-1:0]  code_bits;
      logic [XvalW-1:0]      extra_value;
      logic [XbitsW-1:0]     extra_bits;
      logic                  last_result;
      logic                  tree_done;
   } cl_symbol_type;

   logic clock = 1'b0;
   logic reset;

   clre_req_if req_chan();
   clre_rsp_if rsp_chan();

   code_length_run_length_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [TableW-1:0]   code_tbl [TableDepth];
   logic [CodeLenW-1:0] run_val;
   logic [CountW-1:0]   run_cnt;
   logic [SymW-1:0]     prior_sym;
   logic [CountW-1:0]   run_cap;
   logic [2:0]          run_floor;
   logic                run_live;

   cl_symbol_type       item_symbols[$];
   cl_symbol_type       expected_symbols[$];
   logic [CodeLenW-1:0] tree_lengths[$];

   int mismatch_count = 0;
   bit hold_request   = 1'b0;
   bit send_steady    = 1'b0;
   bit rsp_steady     = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic tree_item_type length_item(input logic [CodeLenW-1:0] len,
                                                 input logic is_last);
      tree_item_type it;
      it.func        = FuncLen;
      it.code_len    = len;
      it.last        = is_last;
      it.table_index = 5'($urandom_range(0, 31));
      it.table_code  = 7'($urandom_range(0, 127));
      it.table_len   = 3'($urandom_range(0, 7));
      return it;
   endfunction

   function automatic tree_item_type load_item(input logic [TableAddrW-1:0] idx,
                                               input logic [TableCodeW-1:0] code,
                                               input logic [TableLenW-1:0] len);
      tree_item_type it;
      it.func        = FuncLoad;
      it.code_len    = 4'($urandom_range(0, 15));
      it.last        = 1'($urandom_range(0, 1));
      it.table_index = idx;
      it.table_code  = code;
      it.table_len   = len;
      return it;
   endfunction

   task automatic clear_run();
      run_val   = '0;
      run_cnt   = '0;
      prior_sym = PriorNone;
      run_cap   = PlainRunMax;
      run_floor = PlainRunMin;
      run_live  = 1'b0;
   endtask

   task automatic add_symbol(input logic [SymW-1:0] sym, input logic [XvalW-1:0] xval,
                             input logic [XbitsW-1:0] xbits);
      cl_symbol_type s;
      s.symbol      = sym;
      s.code_value  = code_tbl[sym][TableCodeW-1:0];
      s.code_bits   = code_tbl[sym][TableW-1:TableCodeW];
      s.extra_value = xval;
      s.extra_bits  = xbits;
      s.last_result = 1'b0;
      s.tree_done   = 1'b0;
      item_symbols.push_back(s);
   endtask

   task automatic emit_run();
      logic [CountW-1:0] n;
      n = run_cnt;
      if (n < {5'd0, run_floor}) begin
         repeat (n) add_symbol({1'b0, run_val}, '0, '0);
      end else if (run_val != '0) begin
         if ({1'b0, run_val} != prior_sym) begin
            add_symbol({1'b0, run_val}, '0, '0);
            n = n - 8'd1;
         end
         add_symbol(SymRep, 7'(n - RepBase), RepXbits);
      end else if (n <= ShortZeroMax) begin
         add_symbol(SymZeroShort, 7'(n - RepBase), ZeroShortXbits);
      end else begin
         add_symbol(SymZeroLong, 7'(n - ZeroLongBase), ZeroLongXbits);
      end
      prior_sym = {1'b0, run_val};
   endtask

   task automatic encode_item(input tree_item_type it);
      logic [CodeLenW-1:0] prev_val;
      item_symbols.delete();
      if (it.func == FuncLoad) begin
         if (it.table_index < TableDepth) code_tbl[it.table_index] = {it.table_len, it.table_code};
         return;
      end
      if (!run_live) begin
         if (it.code_len == '0) begin
            run_cap   = ZeroRunMax;
            run_floor = ShortRunMin;
         end
         run_val  = it.code_len;
         run_cnt  = 8'd1;
         run_live = 1'b1;
      end else if (run_cnt < run_cap && run_val == it.code_len) begin
         run_cnt = run_cnt + 8'd1;
      end else begin
         prev_val = run_val;
         emit_run();
         if (it.code_len == '0) begin
            run_cap   = ZeroRunMax;
            run_floor = ShortRunMin;
         end else if (prev_val == it.code_len) begin
            run_cap   = RepRunMax;
            run_floor = ShortRunMin;
         end else begin
            run_cap   = PlainRunMax;
            run_floor = PlainRunMin;
         end
         run_val = it.code_len;
         run_cnt = 8'd1;
      end
      if (it.last) begin
         emit_run();
         item_symbols[item_symbols.size()-1].tree_done = 1'b1;
         clear_run();
      end
      if (item_symbols.size() > 0) item_symbols[item_symbols.size()-1].last_result = 1'b1;
      foreach (item_symbols[i]) expected_symbols.push_back(item_symbols[i]);
   endtask

   task automatic send_item(input tree_item_type it);
      int gap;
      gap = send_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= it.func;
      req_chan.code_len    <= it.code_len;
      req_chan.last        <= it.last;
      req_chan.table_index <= it.table_index;
      req_chan.table_code  <= it.table_code;
      req_chan.table_len   <= it.table_len;
      do @(posedge clock); while (!req_chan.ready);
      encode_item(it);
   endtask

   task automatic send_lengths(input bit with_loads);
      foreach (tree_lengths[i]) begin
         if (with_loads && $urandom_range(0, 15) == 0)
            send_item(load_item(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                                3'($urandom_range(0, 7))));
         send_item(length_item(tree_lengths[i], i == tree_lengths.size() - 1));
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_symbols.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic make_tree();
      int n;
      int r;
      logic [CodeLenW-1:0] v;
      logic [CodeLenW-1:0] prev_v;
      tree_lengths.delete();
      if ($urandom_range(0, 7) == 0) begin
         // unstructured noise
         n = $urandom_range(1, 12);
         repeat (n) tree_lengths.push_back(4'($urandom_range(0, 15)));
         return;
      end
      prev_v = 4'($urandom_range(0, 15));
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 9);
         if (r < 4) v = '0;
         else if (r < 6) v = prev_v;
         else v = 4'($urandom_range(1, 15));
         n = (v == '0 && $urandom_range(0, 5) == 0) ? $urandom_range(11, 30)
                                                     : $urandom_range(1, 9);
         repeat (n) tree_lengths.push_back(v);
         prev_v = v;
      end
   endtask

   task automatic test_table_load();
      for (int i = 0; i < TableDepth; i++) begin
         if (i == 0) send_item(load_item(5'(i), '0, '0));
         else if (i == TableDepth - 1) send_item(load_item(5'(i), 7'd127, 3'd7));
         else send_item(load_item(5'(i), 7'($urandom_range(0, 127)),
                                  3'($urandom_range(0, 7))));
      end
      send_item(load_item(5'd19, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7))));
      send_item(load_item(5'd31, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7))));
   endtask

   task automatic test_directed_runs();
      tree_lengths.delete();
      repeat (8) tree_lengths.push_back(4'd15);
      send_lengths(1'b0);
      tree_lengths = '{4'd0};
      send_lengths(1'b0);
      tree_lengths = '{4'd0, 4'd0, 4'd0, 4'd7};
      send_lengths(1'b0);
      tree_lengths.delete();
      repeat (11) tree_lengths.push_back(4'd0);
      send_lengths(1'b0);
      wait_drained();
   endtask

   task automatic test_random_trees();
      int lengths_sent;
      lengths_sent = 0;
      while (lengths_sent < RandomItems) begin
         make_tree();
         send_lengths(1'b1);
         lengths_sent += tree_lengths.size();
      end
   endtask

   task automatic test_backpressure();
      tree_lengths.delete();
      repeat (12) tree_lengths.push_back(4'd0);
      repeat (5) tree_lengths.push_back(4'd3);
      tree_lengths.push_back(4'd9);
      tree_lengths.push_back(4'd1);
      tree_lengths.push_back(4'd2);
      tree_lengths.push_back(4'd5);
      tree_lengths.push_back(4'd6);
      tree_lengths.push_back(4'd8);
      send_steady  = 1'b1;
      hold_request = 1'b1;
      send_lengths(1'b0);
      send_steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_no_idle();
      send_steady = 1'b1;
      rsp_steady  = 1'b1;
      make_tree();
      send_lengths(1'b0);
      make_tree();
      send_lengths(1'b0);
      send_steady = 1'b0;
      rsp_steady  = 1'b0;
      wait_drained();
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      cl_symbol_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_symbols.size() == 0) begin
            $error("symbol %0d arrived with nothing pending", rsp_chan.symbol);
            mismatch_count++;
         end else begin
            want = expected_symbols.pop_front();
            check_field("symbol", 8'(want.symbol), 8'(rsp_chan.symbol));
            check_field("code_value", 8'(want.code_value), 8'(rsp_chan.code_value));
            check_field("code_bits", 8'(want.code_bits), 8'(rsp_chan.code_bits));
            check_field("extra_value", 8'(want.extra_value), 8'(rsp_chan.extra_value));
            check_field("extra_bits", 8'(want.extra_bits), 8'(rsp_chan.extra_bits));
            check_field("last_result", 8'(want.last_result), 8'(rsp_chan.last_result));
            check_field("tree_done", 8'(want.tree_done), 8'(rsp_chan.tree_done));
         end
      end
   end

   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LongHold;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rsp_steady || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            stall_left     = pick_gap();
            rsp_chan.ready <= 1'b0;
         end
      end
   end

   initial begin
      #(TimeLimit);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.func        = FuncLoad;
      req_chan.code_len    = '0;
      req_chan.last        = 1'b0;
      req_chan.table_index = '0;
      req_chan.table_code  = '0;
      req_chan.table_len   = '0;
      foreach (code_tbl[i]) code_tbl[i] = '0;
      clear_run();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_table_load();
      test_directed_runs();
      test_random_trees();
      test_backpressure();
      test_no_idle();

      req_chan.valid <= 1'b0;
      for (int i = 0; i < DrainLimit && expected_symbols.size() != 0; i++) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (expected_symbols.size() != 0) begin
         $error("%0d symbols never arrived", expected_symbols.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/clre_pkg.sv
sv/clre_if.sv
sv/clre_ram.sv
sv/clre_run.sv
sv/clre_emit.sv
sv/code_length_run_length_encoder.sv
dv/code_length_run_length_encoder_tb.sv
